### design/thc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package thc_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = 4;
    localparam int RES_MAX    = 19;
    localparam int RES_W      = 5;
    localparam int BUF_BYTES  = 15;
    localparam int ENTRY_W    = 256;

    localparam logic [7:0] F_FIN = 8'h01;
    localparam logic [7:0] F_SYN = 8'h02;
    localparam logic [7:0] F_RST = 8'h04;
    localparam logic [7:0] F_PSH = 8'h08;
    localparam logic [7:0] F_ACK = 8'h10;
    localparam logic [7:0] F_URG = 8'h20;

    localparam logic [7:0] CH_U = 8'h01;
    localparam logic [7:0] CH_W = 8'h02;
    localparam logic [7:0] CH_A = 8'h04;
    localparam logic [7:0] CH_S = 8'h08;
    localparam logic [7:0] CH_P = 8'h10;
    localparam logic [7:0] CH_I = 8'h20;
    localparam logic [7:0] CH_C = 8'h40;
    localparam logic [7:0] SPEC_I = CH_S | CH_W | CH_U;
    localparam logic [7:0] SPEC_D = CH_S | CH_A | CH_W | CH_U;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [5:0] STD_HDR_LEN = 6'd20;

    typedef enum logic [1:0] {
        PT_PLAIN  = 2'd0,
        PT_UNCOMP = 2'd1,
        PT_COMP   = 2'd2
    } pkt_type_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROBE,
        BK_MISS,
        BK_EVAL,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic [63:0] address_pair;
        logic [31:0] port_pair;
        logic [31:0] fixed;
        logic [15:0] tlen;
        logic [15:0] ident;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] win;
        logic [15:0] urg;
        logic [15:0] cks;
        logic [6:0]  hlen;
        logic        hdr_std;
        logic        plain;
    } item_t;

    typedef struct packed {
        logic [1:0]  len;
        logic [23:0] bytes;
    } delta_t;

    // first byte on the wire sits in the low bits
    function automatic delta_t put_delta(input logic [15:0] v);
        delta_t d;
        if (v == 16'd0 || v[15:8] != 8'd0) begin
            d.len   = 2'd3;
            d.bytes = {v[7:0], v[15:8], 8'd0};
        end else begin
            d.len   = 2'd1;
            d.bytes = {16'd0, v[7:0]};
        end
        return d;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x);
        return (x == SLOT_W'(SLOT_COUNT - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] x);
        return (x == '0) ? SLOT_W'(SLOT_COUNT - 1) : x - 1'b1;
    endfunction

endpackage
`default_nettype wire

### design/tcp_header_compressor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake            payload
// s_        s_valid / s_ready    parsed IPv4/TCP header fields
// m_        m_valid / m_ready    one result word per cycle unless m_ready stalls, m_last ends the run
// cfg_      cfg_valid/cfg_ready  cfg_elide_slot_id
//
// A plain IP header skips the slot search. A TCP header goes through a slot
// search (last sent slot, then the 16 slots from the oldest, one
// table read per cycle), an evaluate step, then its result words.
// Reset (aresetn low, synchronous) clears the slot valid bits, so all slots
// read as zero. A two-word input queue accepts up to two headers while the
// back end is busy or results stall; s_ready drops when it is full.
module tcp_header_compressor_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_address_pair,
    input  wire logic [31:0] s_port_pair,
    input  wire logic [31:0] s_ip_fixed_bytes,
    input  wire logic [15:0] s_total_length,
    input  wire logic [15:0] s_ident,
    input  wire logic [15:0] s_fragment_field,
    input  wire logic [31:0] s_seq_number,
    input  wire logic [31:0] s_ack_number,
    input  wire logic [15:0] s_offset_flags,
    input  wire logic [15:0] s_window,
    input  wire logic [15:0] s_urgent_pointer,
    input  wire logic [15:0] s_tcp_checksum,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_packet_type,
    output logic [3:0]       m_slot,
    output logic [6:0]       m_header_length,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_elide_slot_id
);
    import thc_pkg::*;

    logic  elide_reg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elide_reg <= 1'b0;
        end else if (cfg_valid) begin
            elide_reg <= cfg_elide_slot_id;
        end
    end

    thc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_address_pair   (s_address_pair),
        .s_port_pair      (s_port_pair),
        .s_ip_fixed_bytes (s_ip_fixed_bytes),
        .s_total_length   (s_total_length),
        .s_ident          (s_ident),
        .s_fragment_field (s_fragment_field),
        .s_seq_number     (s_seq_number),
        .s_ack_number     (s_ack_number),
        .s_offset_flags   (s_offset_flags),
        .s_window         (s_window),
        .s_urgent_pointer (s_urgent_pointer),
        .s_tcp_checksum   (s_tcp_checksum),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop)
    );

    thc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .elide_slot_id   (elide_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_type   (m_packet_type),
        .m_slot          (m_slot),
        .m_header_length (m_header_length),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_last          (m_last)
    );

endmodule
`default_nettype wire

### design/thc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module thc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [63:0]   s_address_pair,
    input  wire logic [31:0]   s_port_pair,
    input  wire logic [31:0]   s_ip_fixed_bytes,
    input  wire logic [15:0]   s_total_length,
    input  wire logic [15:0]   s_ident,
    input  wire logic [15:0]   s_fragment_field,
    input  wire logic [31:0]   s_seq_number,
    input  wire logic [31:0]   s_ack_number,
    input  wire logic [15:0]   s_offset_flags,
    input  wire logic [15:0]   s_window,
    input  wire logic [15:0]   s_urgent_pointer,
    input  wire logic [15:0]   s_tcp_checksum,
    output logic               q_valid,
    output thc_pkg::item_t     q_item,
    input  wire logic          q_pop
);
    import thc_pkg::*;

    item_t      queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      cls;
    logic [5:0] iplen, tcplen;
    logic       push;

    always_comb begin
        iplen  = {s_ip_fixed_bytes[27:24], 2'b00};
        tcplen = {s_offset_flags[15:12], 2'b00};
        cls.address_pair = s_address_pair;
        cls.port_pair    = s_port_pair;
        cls.fixed        = s_ip_fixed_bytes;
        cls.tlen         = s_total_length;
        cls.ident        = s_ident;
        cls.seq          = s_seq_number;
        cls.ack          = s_ack_number;
        cls.flags        = s_offset_flags[7:0];
        cls.win          = s_window;
        cls.urg          = s_urgent_pointer;
        cls.cks          = s_tcp_checksum;
        cls.hlen         = {1'b0, iplen} + {1'b0, tcplen};
        cls.hdr_std      = (iplen == STD_HDR_LEN) && (tcplen == STD_HDR_LEN);
        // fragments, non-TCP and anything with SYN, FIN or RST set or ACK clear go out as plain IP
        cls.plain = (s_fragment_field[13:0] != 14'd0) ||
                    (s_ip_fixed_bytes[7:0] != PROTO_TCP) ||
                    ((s_offset_flags[7:0] & (F_SYN | F_FIN | F_RST | F_ACK)) != F_ACK);
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

### design/thc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module thc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           elide_slot_id,
    input  wire logic           q_valid,
    input  wire thc_pkg::item_t q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [1:0]          m_packet_type,
    output logic [3:0]          m_slot,
    output logic [6:0]          m_header_length,
    output logic [7:0]          m_out_byte,
    output logic                m_byte_valid,
    output logic                m_last
);
    import thc_pkg::*;

    bk_state_t state_reg, state_next;

    logic [ENTRY_W-1:0] slot_mem_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_vld_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic               pend_reg;
    logic [SLOT_W-1:0]  pend_idx_reg;

    item_t              cur_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [SLOT_W-1:0]  j_reg;
    logic               miss_reg;
    logic [SLOT_W-1:0]  last_sent_reg;
    logic [SLOT_W-1:0]  oldest_reg;
    logic [SLOT_W-1:0]  scan_reg;
    logic [RES_W-1:0]   cnt_reg;

    pkt_type_t          res_type_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [6:0]         res_hlen_reg;
    logic [RES_MAX*8-1:0] res_vec_reg;
    logic [RES_W-1:0]   res_cnt_reg;
    logic [RES_W-1:0]   e_reg;

    logic [1:0]  m_type_reg;
    logic [3:0]  m_slot_reg;
    logic [6:0]  m_hlen_reg;
    logic [7:0]  m_byte_reg;
    logic        m_bv_reg;
    logic        m_last_reg;
    logic        m_valid_reg;

    // control
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              hit;
    logic              load_entry;
    logic              do_write;
    logic              out_load;
    logic              probe_done;
    logic [ENTRY_W-1:0] rd_eff;

    // evaluation
    logic [31:0] e_fixed, e_seq, e_ack;
    logic [15:0] e_len, e_id, e_win, e_urg;
    logic [15:0] dw, did;
    logic [31:0] dA, dS;
    logic [16:0] ldiff;
    logic        len_match, rescue, drop, slot_sent;
    logic [7:0]  ch, mask, slot_byte;
    logic [127:0] buf_v;
    logic [3:0]  n;
    delta_t      dt;
    logic [RES_MAX*8-1:0] vec;
    logic [RES_W-1:0] vcnt;

    assign rd_eff     = rd_vld_reg ? rd_data_reg : '0;
    assign hit        = pend_reg && (rd_eff[255:160] == {cur_reg.address_pair, cur_reg.port_pair});
    assign probe_done = (cnt_reg == RES_W'(SLOT_COUNT + 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (q_valid) state_next = q_item.plain ? BK_EMIT : BK_PROBE;
            BK_PROBE: begin
                if (hit) state_next = BK_EVAL;
                else if (probe_done) state_next = BK_MISS;
            end
            BK_MISS:  state_next = BK_EVAL;
            BK_EVAL:  state_next = BK_EMIT;
            BK_EMIT:  if (out_load && (e_reg == res_cnt_reg - 1'b1)) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = last_sent_reg;
        load_entry = 1'b0;
        do_write   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                q_pop = q_valid;
                rd_en = q_valid && !q_item.plain;
            end
            BK_PROBE: begin
                if (hit) begin
                    load_entry = 1'b1;
                end else if (!probe_done) begin
                    rd_en   = 1'b1;
                    rd_addr = scan_reg;
                end else begin
                    // no match: reuse the slot just before the oldest
                    rd_en   = 1'b1;
                    rd_addr = slot_dec(oldest_reg);
                end
            end
            BK_MISS: load_entry = 1'b1;
            BK_EVAL: do_write = 1'b1;
            BK_EMIT: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_comb begin
        e_fixed = entry_reg[159:128];
        e_len   = entry_reg[127:112];
        e_id    = entry_reg[111:96];
        e_seq   = entry_reg[95:64];
        e_ack   = entry_reg[63:32];
        e_win   = entry_reg[31:16];
        e_urg   = entry_reg[15:0];

        dw  = cur_reg.win - e_win;
        dA  = cur_reg.ack - e_ack;
        dS  = cur_reg.seq - e_seq;
        did = cur_reg.ident - e_id;
        ldiff = {1'b0, e_len} - {10'd0, cur_reg.hlen};
        len_match = !ldiff[16] && (dS == {16'd0, ldiff[15:0]});

        rescue = miss_reg || !cur_reg.hdr_std || (cur_reg.fixed != e_fixed);
        ch = 8'd0;
        if ((cur_reg.flags & F_URG) != 8'd0) ch = ch | CH_U;
        else if (cur_reg.urg != e_urg) rescue = 1'b1;
        if (dw != 16'd0) ch = ch | CH_W;
        if (dA != 32'd0) begin
            if (dA[31:16] != 16'd0) rescue = 1'b1;
            else ch = ch | CH_A;
        end
        if (dS != 32'd0) begin
            if (dS[31:16] != 16'd0) rescue = 1'b1;
            else ch = ch | CH_S;
        end

        drop = 1'b0;
        if (ch == 8'd0) begin
            if (cur_reg.tlen == e_len || e_len != {9'd0, cur_reg.hlen}) rescue = 1'b1;
        end else if (ch == SPEC_I || ch == SPEC_D) begin
            rescue = 1'b1;
        end else if (ch == (CH_S | CH_A) && dS == dA && len_match) begin
            ch   = SPEC_I;
            drop = 1'b1;
        end else if (ch == CH_S && len_match) begin
            ch   = SPEC_D;
            drop = 1'b1;
        end

        buf_v = '0;
        n     = 4'd0;
        dt    = '0;
        if (!drop) begin
            if ((ch & CH_U) != 8'd0) begin
                dt = put_delta(cur_reg.urg);
                buf_v = buf_v | ({104'd0, dt.bytes} << {n, 3'b000});
                n = n + {2'b00, dt.len};
            end
            if ((ch & CH_W) != 8'd0) begin
                dt = put_delta(dw);
                buf_v = buf_v | ({104'd0, dt.bytes} << {n, 3'b000});
                n = n + {2'b00, dt.len};
            end
            if ((ch & CH_A) != 8'd0) begin
                dt = put_delta(dA[15:0]);
                buf_v = buf_v | ({104'd0, dt.bytes} << {n, 3'b000});
                n = n + {2'b00, dt.len};
            end
            if ((ch & CH_S) != 8'd0) begin
                dt = put_delta(dS[15:0]);
                buf_v = buf_v | ({104'd0, dt.bytes} << {n, 3'b000});
                n = n + {2'b00, dt.len};
            end
        end
        if (did != 16'd1) begin
            dt = put_delta(did);
            buf_v = buf_v | ({104'd0, dt.bytes} << {n, 3'b000});
            n = n + {2'b00, dt.len};
            ch = ch | CH_I;
        end
        if ((cur_reg.flags & F_PSH) != 8'd0) ch = ch | CH_P;

        slot_sent = (last_sent_reg != j_reg) || !elide_slot_id;
        slot_byte = {{(8-SLOT_W){1'b0}}, j_reg};
        if (slot_sent) begin
            mask = ch | CH_C;
            vec  = {buf_v[BUF_BYTES*8-1:0], cur_reg.cks[7:0], cur_reg.cks[15:8],
                    slot_byte, mask};
            vcnt = {1'b0, n} + RES_W'(4);
        end else begin
            mask = ch;
            vec  = {8'd0, buf_v[BUF_BYTES*8-1:0], cur_reg.cks[7:0],
                    cur_reg.cks[15:8], mask};
            vcnt = {1'b0, n} + RES_W'(3);
        end
    end

    // slot table: one read port, registered, one write port
    always_ff @(posedge aclk) begin
        if (do_write) begin
            slot_mem_reg[j_reg] <= {cur_reg.address_pair, cur_reg.port_pair, cur_reg.fixed,
                                    cur_reg.tlen, cur_reg.ident, cur_reg.seq, cur_reg.ack,
                                    cur_reg.win, cur_reg.urg};
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            state_reg     <= BK_IDLE;
            last_sent_reg <= '0;
            oldest_reg    <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            if (rd_en) rd_vld_reg <= slot_vld_reg[rd_addr];
            if (do_write) begin
                slot_vld_reg[j_reg] <= 1'b1;
                last_sent_reg       <= j_reg;
            end
            if (state_reg == BK_IDLE && q_valid) cnt_reg <= RES_W'(1);
            else if (state_reg == BK_PROBE && rd_en && !probe_done) cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == BK_PROBE && !hit && probe_done) oldest_reg <= slot_dec(oldest_reg);
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) pend_idx_reg <= rd_addr;
        if (load_entry) entry_reg <= rd_eff;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    cur_reg  <= q_item;
                    scan_reg <= oldest_reg;
                    e_reg    <= '0;
                    res_type_reg <= PT_PLAIN;
                    res_slot_reg <= '0;
                    res_hlen_reg <= '0;
                    res_vec_reg  <= '0;
                    res_cnt_reg  <= RES_W'(1);
                end
            end
            BK_PROBE: begin
                if (hit) begin
                    j_reg    <= pend_idx_reg;
                    miss_reg <= 1'b0;
                end else if (!probe_done) begin
                    scan_reg <= slot_inc(scan_reg);
                end else begin
                    j_reg    <= slot_dec(oldest_reg);
                    miss_reg <= 1'b1;
                end
            end
            BK_EVAL: begin
                e_reg        <= '0;
                res_slot_reg <= j_reg;
                res_hlen_reg <= cur_reg.hlen;
                if (rescue) begin
                    res_type_reg <= PT_UNCOMP;
                    res_vec_reg  <= '0;
                    res_cnt_reg  <= RES_W'(1);
                end else begin
                    res_type_reg <= PT_COMP;
                    res_vec_reg  <= vec;
                    res_cnt_reg  <= vcnt;
                end
            end
            BK_EMIT: begin
                if (out_load) begin
                    e_reg      <= e_reg + 1'b1;
                    m_type_reg <= res_type_reg;
                    m_slot_reg <= res_slot_reg;
                    m_hlen_reg <= res_hlen_reg;
                    m_byte_reg <= res_vec_reg[{e_reg, 3'b000} +: 8];
                    m_bv_reg   <= (res_type_reg == PT_COMP);
                    m_last_reg <= (e_reg == res_cnt_reg - 1'b1);
                end
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_packet_type   = m_type_reg;
    assign m_slot          = m_slot_reg;
    assign m_header_length = m_hlen_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_byte_valid    = m_bv_reg;
    assign m_last          = m_last_reg;

endmodule
`default_nettype wire

### tb/sv/tb_tcp_header_compressor_core.sv
`timescale 1ns / 1ps
module tb_tcp_header_compressor_core;
    import thc_pkg::*;

    typedef struct {
        logic [63:0] address_pair;
        logic [31:0] port_pair;
        logic [31:0] fixed;
        logic [15:0] tlen;
        logic [15:0] ident;
        logic [15:0] frag;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] offl;
        logic [15:0] win;
        logic [15:0] urg;
        logic [15:0] cks;
    } hdr_t;

    typedef struct packed {
        logic [1:0] ptype;
        logic [3:0] slot;
        logic [6:0] hlen;
        logic [7:0] data;
        logic       bvalid;
        logic       last;
    } word_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_address_pair = '0;
    logic [31:0] s_port_pair = '0;
    logic [31:0] s_ip_fixed_bytes = '0;
    logic [15:0] s_total_length = '0;
    logic [15:0] s_ident = '0;
    logic [15:0] s_fragment_field = '0;
    logic [31:0] s_seq_number = '0;
    logic [31:0] s_ack_number = '0;
    logic [15:0] s_offset_flags = '0;
    logic [15:0] s_window = '0;
    logic [15:0] s_urgent_pointer = '0;
    logic [15:0] s_tcp_checksum = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_packet_type;
    logic [3:0]  m_slot;
    logic [6:0]  m_header_length;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_elide_slot_id = 1'b0;

    tcp_header_compressor_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_address_pair(s_address_pair), .s_port_pair(s_port_pair),
        .s_ip_fixed_bytes(s_ip_fixed_bytes), .s_total_length(s_total_length),
        .s_ident(s_ident), .s_fragment_field(s_fragment_field),
        .s_seq_number(s_seq_number), .s_ack_number(s_ack_number),
        .s_offset_flags(s_offset_flags), .s_window(s_window),
        .s_urgent_pointer(s_urgent_pointer), .s_tcp_checksum(s_tcp_checksum),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_packet_type(m_packet_type), .m_slot(m_slot),
        .m_header_length(m_header_length), .m_out_byte(m_out_byte),
        .m_byte_valid(m_byte_valid), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_elide_slot_id(cfg_elide_slot_id)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor copy of the connection table
    logic [63:0] tbl_addr [SLOT_COUNT];
    logic [31:0] tbl_ports [SLOT_COUNT];
    logic [31:0] tbl_fixed [SLOT_COUNT];
    logic [15:0] tbl_len [SLOT_COUNT];
    logic [15:0] tbl_id [SLOT_COUNT];
    logic [31:0] tbl_seq [SLOT_COUNT];
    logic [31:0] tbl_ack [SLOT_COUNT];
    logic [15:0] tbl_win [SLOT_COUNT];
    logic [15:0] tbl_urg [SLOT_COUNT];
    logic [3:0]  last_slot;
    logic [3:0]  oldest;
    logic        elide;

    word_t expected_words[$];
    int    mismatches = 0;
    int    words_checked = 0;
    int    headers_sent = 0;
    int    comp_count = 0;
    int    uncomp_count = 0;
    int    plain_count = 0;
    int    idle_pct = 29;
    int    quiet_cycles = 0;

    // random header pool for connection reuse
    hdr_t  flows[8];

    function automatic void push_delta(ref logic [7:0] bytes[$], input logic [15:0] v);
        if (v == 16'd0 || v[15:8] != 8'd0) begin
            bytes.push_back(8'd0);
            bytes.push_back(v[15:8]);
            bytes.push_back(v[7:0]);
        end else begin
            bytes.push_back(v[7:0]);
        end
    endfunction

    task automatic compress_header(input hdr_t h);
        logic [7:0]  flags;
        logic [6:0]  iplen, tcplen, hl;
        logic [3:0]  j;
        logic        found, uncomp;
        logic [7:0]  chg;
        logic [31:0] ds, da;
        logic [15:0] d, oldlen, oldid;
        logic [7:0]  bytes[$];
        word_t       w;
        int          k;
        flags  = h.offl[7:0];
        iplen  = {1'b0, h.fixed[27:24], 2'b00};
        tcplen = {1'b0, h.offl[15:12], 2'b00};
        hl     = iplen + tcplen;
        found  = 1'b0;
        uncomp = 1'b0;
        chg    = '0;
        ds     = '0;
        da     = '0;
        if (h.frag[13:0] != 0 || h.fixed[7:0] != PROTO_TCP ||
            (flags & (F_SYN | F_FIN | F_RST | F_ACK)) != F_ACK) begin
            w = '{PT_PLAIN, 4'd0, 7'd0, 8'd0, 1'b0, 1'b1};
            expected_words.push_back(w);
            plain_count++;
            return;
        end
        j = last_slot;
        if (tbl_addr[j] == h.address_pair && tbl_ports[j] == h.port_pair) begin
            found = 1'b1;
        end else begin
            for (k = 0; k < SLOT_COUNT && !found; k++) begin
                if (tbl_addr[4'(oldest + k)] == h.address_pair &&
                    tbl_ports[4'(oldest + k)] == h.port_pair) begin
                    j = 4'(oldest + k);
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            j = oldest - 1'b1;
            oldest = j;
            uncomp = 1'b1;
        end
        oldlen = tbl_len[j];
        oldid  = tbl_id[j];
        if (!uncomp && (h.fixed != tbl_fixed[j] || iplen != 20 || tcplen != 20))
            uncomp = 1'b1;
        if (!uncomp) begin
            if (flags & F_URG) begin
                push_delta(bytes, h.urg);
                chg |= CH_U;
            end else if (h.urg != tbl_urg[j]) begin
                uncomp = 1'b1;
            end
        end
        if (!uncomp) begin
            d = h.win - tbl_win[j];
            if (d != 0) begin
                push_delta(bytes, d);
                chg |= CH_W;
            end
            da = h.ack - tbl_ack[j];
            if (da != 0) begin
                if (da > 32'hffff) uncomp = 1'b1;
                else begin
                    push_delta(bytes, da[15:0]);
                    chg |= CH_A;
                end
            end
        end
        if (!uncomp) begin
            ds = h.seq - tbl_seq[j];
            if (ds != 0) begin
                if (ds > 32'hffff) uncomp = 1'b1;
                else begin
                    push_delta(bytes, ds[15:0]);
                    chg |= CH_S;
                end
            end
        end
        if (!uncomp) begin
            if (chg == 0) begin
                if (h.tlen == oldlen || oldlen != 16'(hl)) uncomp = 1'b1;
            end else if (chg == SPEC_I || chg == SPEC_D) begin
                uncomp = 1'b1;
            end else if (chg == (CH_S | CH_A)) begin
                if (ds == da && ds == 32'(oldlen) - 32'(hl)) begin
                    chg = SPEC_I;
                    bytes.delete();
                end
            end else if (chg == CH_S) begin
                if (ds == 32'(oldlen) - 32'(hl)) begin
                    chg = SPEC_D;
                    bytes.delete();
                end
            end
        end
        if (!uncomp) begin
            d = h.ident - oldid;
            if (d != 16'd1) begin
                push_delta(bytes, d);
                chg |= CH_I;
            end
            if (flags & F_PSH) chg |= CH_P;
        end
        tbl_addr[j]  = h.address_pair;
        tbl_ports[j] = h.port_pair;
        tbl_fixed[j] = h.fixed;
        tbl_len[j]   = h.tlen;
        tbl_id[j]    = h.ident;
        tbl_seq[j]   = h.seq;
        tbl_ack[j]   = h.ack;
        tbl_win[j]   = h.win;
        tbl_urg[j]   = h.urg;
        if (uncomp) begin
            last_slot = j;
            expected_words.push_back('{PT_UNCOMP, j, hl, 8'd0, 1'b0, 1'b1});
            uncomp_count++;
            return;
        end
        comp_count++;
        if (last_slot != j || !elide) begin
            last_slot = j;
            expected_words.push_back('{PT_COMP, j, hl, chg | CH_C, 1'b1, 1'b0});
            expected_words.push_back('{PT_COMP, j, hl, 8'(j), 1'b1, 1'b0});
        end else begin
            expected_words.push_back('{PT_COMP, j, hl, chg, 1'b1, 1'b0});
        end
        expected_words.push_back('{PT_COMP, j, hl, h.cks[15:8], 1'b1, 1'b0});
        expected_words.push_back('{PT_COMP, j, hl, h.cks[7:0], 1'b1,
                                   bytes.size() == 0});
        for (k = 0; k < bytes.size() && k < BUF_BYTES; k++)
            expected_words.push_back('{PT_COMP, j, hl, bytes[k], 1'b1,
                                       k + 1 == bytes.size()});
    endtask

    // called at a falling edge; valid stays up into the next header when there is no gap
    task automatic send_header(input hdr_t h);
        while (($urandom_range(99) < idle_pct)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_address_pair   <= h.address_pair;
        s_port_pair      <= h.port_pair;
        s_ip_fixed_bytes <= h.fixed;
        s_total_length   <= h.tlen;
        s_ident          <= h.ident;
        s_fragment_field <= h.frag;
        s_seq_number     <= h.seq;
        s_ack_number     <= h.ack;
        s_offset_flags   <= h.offl;
        s_window         <= h.win;
        s_urgent_pointer <= h.urg;
        s_tcp_checksum   <= h.cks;
        s_valid          <= 1'b1;
        compress_header(h);
        headers_sent++;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_and_wait();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_elide(input logic v);
        drain_and_wait();
        cfg_elide_slot_id <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        elide = v;
    endtask

    function automatic hdr_t base_header(input logic [63:0] a, input logic [31:0] p);
        hdr_t h;
        h.address_pair = a;
        h.port_pair    = p;
        h.fixed        = {8'h45, 8'h00, 8'h40, PROTO_TCP};
        h.tlen         = 16'd40;
        h.ident        = 16'd0;
        h.frag         = 16'h4000;
        h.seq          = 32'd0;
        h.ack          = 32'd0;
        h.offl         = {4'd5, 4'd0, F_ACK};
        h.win          = 16'd0;
        h.urg          = 16'd0;
        h.cks          = $urandom;
        return h;
    endfunction

    // monitor: compare each accepted word with the oldest expectation
    always @(posedge aclk) begin
        word_t got, want;
        if (aresetn && m_valid && m_ready) begin
            quiet_cycles <= 0;
            got = '{m_packet_type, m_slot, m_header_length, m_out_byte,
                    m_byte_valid, m_last};
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp type %0d slot %0d hlen %0d byte %h bv %b last %b",
                                 want.ptype, want.slot, want.hlen, want.data,
                                 want.bvalid, want.last);
                        $display("          got type %0d slot %0d hlen %0d byte %h bv %b last %b",
                                 got.ptype, got.slot, got.hlen, got.data,
                                 got.bvalid, got.last);
                    end
                end
            end
        end else if (s_valid && s_ready) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_plain_ip();
        hdr_t h;
        h = base_header(64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        h.frag = 16'h0001;                 // fragment
        send_header(h);
        h = base_header('0, '0);
        h.fixed[7:0] = 8'd17;              // UDP
        send_header(h);
        h = base_header(64'h1, 32'h1);
        h.offl[7:0] = F_ACK | F_SYN;
        send_header(h);
        h.offl[7:0] = F_ACK | F_FIN;
        send_header(h);
        h.offl[7:0] = F_ACK | F_RST;
        send_header(h);
        h.offl[7:0] = F_PSH;               // ACK clear
        send_header(h);
    endtask

    task automatic test_directed_flow();
        hdr_t h;
        h = base_header(64'hc0a8_0001_0a00_0002, 32'h1234_0050);
        send_header(h);                    // new connection, uncompressed
        h.ident++; h.seq += 100; h.tlen = 140;
        send_header(h);                    // seq only
        h.ident++; h.seq += 100; h.ack += 100;
        send_header(h);                    // seq and ack equal to last data
        h.ident++; h.seq += 100;
        send_header(h);
        h.ident += 300; h.win = 16'hffff; h.offl[7:0] = F_ACK | F_PSH | F_URG;
        h.urg = 16'hffff;
        send_header(h);                    // urgent, window, ident deltas
        h.ident++; h.ack += 16'hffff; h.seq += 256; h.offl[7:0] = F_ACK;
        send_header(h);                    // URG cleared, pointer unchanged; ack and seq deltas
        h.ident++; h.urg = 0;
        send_header(h);
        h.ident++; h.ack += 32'h10000;
        send_header(h);                    // ack delta too large
        h.ident++; h.seq += 32'h10000;
        send_header(h);                    // seq delta too large
        h.ident++;
        send_header(h);                    // nothing changed, same length
        h.ident++; h.fixed[27:24] = 4'd6;
        send_header(h);                    // IP options
        h.fixed[27:24] = 4'd5; h.offl[15:12] = 4'd0;
        send_header(h);                    // malformed TCP length
        h.offl[15:12] = 4'd15; h.fixed[27:24] = 4'd15;
        send_header(h);
    endtask

    task automatic test_random_flows(input int count);
        hdr_t h;
        int   f, r;
        for (int i = 0; i < 8; i++) begin
            flows[i] = base_header({$urandom, $urandom}, $urandom);
            flows[i].ident = $urandom;
            flows[i].seq   = $urandom;
            flows[i].ack   = $urandom;
            flows[i].win   = $urandom;
        end
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 75) begin
                f = $urandom_range(7);
                h = flows[f];
                h.ident += ($urandom_range(3) == 0) ? 16'($urandom) : 16'd1;
                h.tlen = 16'(40 + $urandom_range(3) * $urandom_range(600));
                case ($urandom_range(5))
                    0: h.seq += $urandom_range(255);
                    1: h.seq += $urandom_range(65535);
                    2: begin h.seq += h.tlen - 40; h.ack += h.tlen - 40; end
                    3: h.ack += $urandom_range(300);
                    4: h.win = $urandom;
                    default: ;
                endcase
                h.offl[7:0] = F_ACK | ($urandom_range(1) ? F_PSH : 8'h0) |
                              ($urandom_range(5) == 0 ? F_URG : 8'h0);
                if (h.offl[7:0] & F_URG) h.urg = $urandom;
                h.cks = $urandom;
                flows[f] = h;
                if (h.offl[7:0] & F_URG) flows[f].urg = h.urg;
            end else if (r < 88) begin
                h = base_header({$urandom, $urandom}, $urandom);
                h.seq = $urandom;
            end else begin
                h.address_pair = {$urandom, $urandom};
                h.port_pair = $urandom;
                h.fixed = $urandom;
                if ($urandom_range(1)) h.fixed[7:0] = PROTO_TCP;
                h.tlen = $urandom; h.ident = $urandom; h.frag = $urandom;
                h.seq = $urandom; h.ack = $urandom; h.offl = $urandom;
                h.win = $urandom; h.urg = $urandom; h.cks = $urandom;
            end
            send_header(h);
        end
    endtask

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_addr[i] = '0; tbl_ports[i] = '0; tbl_fixed[i] = '0;
            tbl_len[i] = '0; tbl_id[i] = '0; tbl_seq[i] = '0;
            tbl_ack[i] = '0; tbl_win[i] = '0; tbl_urg[i] = '0;
        end
        last_slot = '0;
        oldest = '0;
        elide = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_elide(1'b0);
        test_plain_ip();
        test_directed_flow();
        write_elide(1'b1);
        test_directed_flow();
        idle_pct = 0;                       // long stretch at full rate
        test_random_flows(20);
        idle_pct = 29;
        write_elide(1'b0);
        test_random_flows(40);
        write_elide(1'b1);
        test_random_flows(40);
        drain_and_wait();
        $display("Sent %0d headers: %0d compressed, %0d uncompressed, %0d plain IP;",
                 headers_sent, comp_count, uncomp_count, plain_count);
        $display("checked %0d result words with slot id elision off and on.",
                 words_checked);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
